### src/paik_pkg.sv
package paik_pkg;

    // CORDIC depth, limited by the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_EFF    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int COR_LAT       = CORDIC_EFF + 1;

    // datapath widths
    localparam int CW         = 48;          // CORDIC vector width
    localparam int AW         = 26;          // angle accumulator, Q16 degrees
    localparam int ISQ_IN_W   = 52;          // square root radicand
    localparam int ISQ_STAGES = ISQ_IN_W / 2;

    // geometry, Q8 cm and Q16 cm^2
    localparam int X_MIN     = 21 * 256;
    localparam int X_MAX     = 46 * 256;
    localparam int WRIST_LEN = 19 * 256;
    localparam int REACH_SQ  = 729 * 65536;
    localparam int D_Q16     = 364 * 65536;
    localparam int N_OFF     = 365 * 65536;
    localparam int K1_BASE   = 13 * D_Q16;

    // angle constants, Q16 degrees
    localparam int DEG90     = 5898240;
    localparam int ELBOW_OFF = 150 * 65536;
    localparam int WRIST_OFF = 60 * 65536;

    // divide by ten: floor(a * RECIP10 >> RECIP_SH), exact below 699050
    localparam int RECIP10  = 419431;
    localparam int RECIP_SH = 22;

    // arctan(2^-i) in Q16 degrees
    function automatic logic [21:0] atan_q16(input int i);
        logic [21:0] r;
        case (i)
            0:       r = 22'd2949120;
            1:       r = 22'd1740967;
            2:       r = 22'd919879;
            3:       r = 22'd466945;
            4:       r = 22'd234379;
            5:       r = 22'd117304;
            6:       r = 22'd58666;
            7:       r = 22'd29335;
            8:       r = 22'd14668;
            9:       r = 22'd7334;
            10:      r = 22'd3667;
            11:      r = 22'd1833;
            12:      r = 22'd917;
            13:      r = 22'd458;
            14:      r = 22'd229;
            15:      r = 22'd115;
            16:      r = 22'd57;
            17:      r = 22'd29;
            18:      r = 22'd14;
            19:      r = 22'd7;
            20:      r = 22'd4;
            21:      r = 22'd2;
            22:      r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

### src/paik_isqrt.sv
// Pipelined integer square root, one result bit per stage
module paik_isqrt
    import paik_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ISQ_IN_W-1:0]   rad,
    output logic [ISQ_STAGES-1:0] root
);

    localparam int RW = ISQ_STAGES + 1;

    logic [RW-1:0]         rem_reg  [ISQ_STAGES];
    logic [ISQ_STAGES-1:0] root_reg [ISQ_STAGES];
    logic [ISQ_IN_W-1:0]   rad_reg  [ISQ_STAGES];

    genvar k;
    generate
        for (k = 0; k < ISQ_STAGES; k++)
        begin : g_stage
            logic [RW-1:0]         rem_in;
            logic [ISQ_STAGES-1:0] root_in;
            logic [ISQ_IN_W-1:0]   rad_in;
            logic [RW+1:0]         rem_sh;
            logic [RW+1:0]         trial;
            logic [RW+1:0]         diff;
            logic                  ge;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign rad_in  = rad;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign rad_in  = rad_reg[k-1];
            end

            // bring down two bits, try root*4+1
            assign rem_sh = {rem_in, rad_in[ISQ_IN_W-1 -: 2]};
            assign trial  = {1'b0, root_in, 2'b01};
            assign ge     = (rem_sh >= trial);
            assign diff   = rem_sh - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
                    root_reg[k] <= {root_in[ISQ_STAGES-2:0], ge};
                    rad_reg[k]  <= {rad_in[ISQ_IN_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[ISQ_STAGES-1];

endmodule

### src/paik_cordic.sv
// Vectoring CORDIC atan2, quadrant fold then one micro-rotation per stage
module paik_cordic
    import paik_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic signed [AW-1:0] ang
);

    localparam logic signed [AW-1:0] DEG90_Q = AW'(DEG90);

    logic signed [CW-1:0] x_reg [COR_LAT];
    logic signed [CW-1:0] y_reg [COR_LAT];
    logic signed [AW-1:0] a_reg [COR_LAT];
    logic                 z_reg [COR_LAT];

    logic signed [CW-1:0] x0, y0;
    logic signed [AW-1:0] a0;

    // fold the left half plane onto the right
    always_comb
    begin
        x0 = x_in;
        y0 = y_in;
        a0 = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x0 = y_in;
                y0 = -x_in;
                a0 = DEG90_Q;
            end
            else
            begin
                x0 = -y_in;
                y0 = x_in;
                a0 = -DEG90_Q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            a_reg[0] <= a0;
            z_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_EFF; i++)
        begin : g_rot
            logic signed [CW-1:0] xs, ys;
            logic signed [AW-1:0] at;

            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            assign at = signed'({{(AW-22){1'b0}}, atan_q16(i)});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (y_reg[i] > 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + ys;
                        y_reg[i+1] <= y_reg[i] - xs;
                        a_reg[i+1] <= a_reg[i] + at;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - ys;
                        y_reg[i+1] <= y_reg[i] + xs;
                        a_reg[i+1] <= a_reg[i] - at;
                    end
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    endgenerate

    // zero vector gives zero angle
    assign ang = z_reg[COR_LAT-1] ? '0 : a_reg[COR_LAT-1];

endmodule

### src/planar_arm_inverse_kinematics_top.sv
// Channel   Direction  Handshake                    Word
// target    in         target_valid/target_ready    target_x, target_y, target_z
// result    out        result_valid/result_ready    base_angle, shoulder_angle,
//                                                   elbow_angle, wrist_angle, reach_ok
//
// One word per cycle sustained while the output is not held; the pipeline holds
// the two 26-stage square roots and the CORDIC chain. Reset clears only the valid
// bits of the pipeline.
// A held result freezes every stage at once; target_ready follows
// !result_valid || result_ready, so nothing is dropped or repeated.
module planar_arm_inverse_kinematics_top
    import paik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               target_valid,
    output logic               target_ready,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic signed [15:0] target_z,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [15:0] base_angle,
    output logic signed [15:0] shoulder_angle,
    output logic signed [15:0] elbow_angle,
    output logic signed [15:0] wrist_angle,
    output logic               reach_ok
);

    localparam int VLAT = 3 + ISQ_STAGES + 5 + ISQ_STAGES + 3 + COR_LAT + 1;

    typedef struct packed {
        logic [13:0]        px;
        logic signed [15:0] z;
        logic signed [15:0] bq;
    } side1_t;

    typedef struct packed {
        logic [12:0]        wx;
        logic signed [15:0] wy;
        logic signed [26:0] n;
        logic               ok;
        logic signed [15:0] bq;
    } side2_t;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] bq;
    } side3_t;

    logic [VLAT-1:0] vld_reg;
    logic            adv;

    assign adv          = !vld_reg[VLAT-1] || result_ready;
    assign target_ready = adv;
    assign result_valid = vld_reg[VLAT-1];

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[VLAT-2:0], target_valid};
        end
    end

    // stage 0: clamp x, start y * 0.9
    logic [13:0]        px0_reg;
    logic signed [15:0] z0_reg;
    logic [18:0]        ba0_reg;
    logic               bneg0_reg;
    logic [13:0]        px_c;
    logic signed [19:0] nine_y;
    logic signed [19:0] nine_abs;

    always_comb
    begin
        if (target_x < 16'(X_MIN))
            px_c = 14'(X_MIN);
        else if (target_x > 16'(X_MAX))
            px_c = 14'(X_MAX);
        else
            px_c = target_x[13:0];
        nine_y   = {target_y[15], target_y[15:0], 3'b000} + 20'(target_y);
        nine_abs = nine_y[19] ? -nine_y : nine_y;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg   <= px_c;
            z0_reg    <= target_z;
            ba0_reg   <= nine_abs[18:0] + 19'd5;
            bneg0_reg <= nine_y[19];
        end
    end

    // stage 1: dx squared, finish the rounded division by ten
    logic [25:0]        dxsq1_reg;
    logic [13:0]        px1_reg;
    logic signed [15:0] z1_reg;
    logic signed [15:0] bq1_reg;
    logic [12:0]        dx;
    logic [37:0]        bprod;
    logic [15:0]        bquo;

    assign dx    = 13'(px0_reg - 14'(X_MIN));
    assign bprod = 38'(ba0_reg) * 38'(RECIP10);
    assign bquo  = bprod[RECIP_SH +: 16];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxsq1_reg <= 26'(dx) * 26'(dx);
            px1_reg   <= px0_reg;
            z1_reg    <= z0_reg;
            bq1_reg   <= bneg0_reg ? -signed'(bquo) : signed'(bquo);
        end
    end

    // stage 2: radicand of the z limit
    logic [25:0] rad1_reg;
    side1_t      sd2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad1_reg   <= 26'(REACH_SQ) - dxsq1_reg;
            sd2_reg.px <= px1_reg;
            sd2_reg.z  <= z1_reg;
            sd2_reg.bq <= bq1_reg;
        end
    end

    // z limit square root, side data delayed alongside
    logic [ISQ_STAGES-1:0] zroot;
    side1_t                s1d_reg [ISQ_STAGES];

    paik_isqrt u_isqrt_z
    (
        .clk  (clk),
        .en   (adv),
        .rad  ({{(ISQ_IN_W-26){1'b0}}, rad1_reg}),
        .root (zroot)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1d_reg[0] <= sd2_reg;
            for (int i = 1; i < ISQ_STAGES; i++)
                s1d_reg[i] <= s1d_reg[i-1];
        end
    end

    // stage 3: clamp z, wrist centre
    side1_t             sd_z;
    logic [12:0]        zmax;
    logic [12:0]        wx3_reg;
    logic signed [15:0] wy3_reg;
    logic signed [15:0] bq3_reg;

    assign sd_z = s1d_reg[ISQ_STAGES-1];
    assign zmax = zroot[12:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wx3_reg <= 13'(sd_z.px - 14'(WRIST_LEN));
            wy3_reg <= (17'(sd_z.z) <= signed'({4'b0000, zmax})) ? sd_z.z
                                                                  : signed'({3'b000, zmax});
            bq3_reg <= sd_z.bq;
        end
    end

    // stage 4: squares
    logic [25:0]        wxsq4_reg;
    logic signed [31:0] wysq4_reg;
    logic [12:0]        wx4_reg;
    logic signed [15:0] wy4_reg;
    logic signed [15:0] bq4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wxsq4_reg <= 26'(wx3_reg) * 26'(wx3_reg);
            wysq4_reg <= 32'(wy3_reg) * 32'(wy3_reg);
            wx4_reg   <= wx3_reg;
            wy4_reg   <= wy3_reg;
            bq4_reg   <= bq3_reg;
        end
    end

    // stage 5: r squared and reach test
    logic [31:0]        r2;
    logic [31:0]        r25_reg;
    logic               ok5_reg;
    logic [12:0]        wx5_reg;
    logic signed [15:0] wy5_reg;
    logic signed [15:0] bq5_reg;

    assign r2 = 32'(wxsq4_reg) + unsigned'(wysq4_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r25_reg <= r2;
            ok5_reg <= (r2 <= 32'(REACH_SQ));
            wx5_reg <= wx4_reg;
            wy5_reg <= wy4_reg;
            bq5_reg <= bq4_reg;
        end
    end

    // stage 6: cosine numerator, D-N and D+N
    logic signed [32:0] nf, dmn, dpn;
    logic [25:0]        dmn6_reg, dpn6_reg;
    side2_t             sd6_reg;

    assign nf  = signed'({1'b0, r25_reg}) - 33'(N_OFF);
    assign dmn = 33'(D_Q16) - nf;
    assign dpn = 33'(D_Q16) + nf;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmn6_reg   <= dmn[25:0];
            dpn6_reg   <= dpn[25:0];
            sd6_reg.wx <= wx5_reg;
            sd6_reg.wy <= wy5_reg;
            sd6_reg.n  <= nf[26:0];
            sd6_reg.ok <= ok5_reg;
            sd6_reg.bq <= bq5_reg;
        end
    end

    // stage 7: radicand of the sine
    logic [51:0] prod7_reg;
    side2_t      sd7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod7_reg <= 52'(dmn6_reg) * 52'(dpn6_reg);
            sd7_reg   <= sd6_reg;
        end
    end

    // sine square root, side data delayed alongside
    logic [ISQ_STAGES-1:0] sroot;
    side2_t                s2d_reg [ISQ_STAGES];

    paik_isqrt u_isqrt_s
    (
        .clk  (clk),
        .en   (adv),
        .rad  (prod7_reg),
        .root (sroot)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2d_reg[0] <= sd7_reg;
            for (int i = 1; i < ISQ_STAGES; i++)
                s2d_reg[i] <= s2d_reg[i-1];
        end
    end

    // stage 8: k1 = 13D + 14N, k2 = 14S
    side2_t             sd_s;
    logic signed [31:0] n32;
    logic signed [31:0] s32;
    logic signed [31:0] k18_reg, k28_reg;
    logic signed [26:0] n8_reg;
    logic [25:0]        s8_reg;
    side2_t             sd8_reg;

    assign sd_s = s2d_reg[ISQ_STAGES-1];
    assign n32  = 32'(sd_s.n);
    assign s32  = signed'({6'b000000, sroot});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k18_reg <= 32'(K1_BASE) + (n32 <<< 4) - (n32 <<< 1);
            k28_reg <= (s32 <<< 4) - (s32 <<< 1);
            n8_reg  <= sd_s.n;
            s8_reg  <= sroot;
            sd8_reg <= sd_s;
        end
    end

    // stage 9: shoulder products
    logic signed [13:0] wx_s;
    logic signed [CW-1:0] yk1_reg, xk2_reg, xk1_reg, yk2_reg;
    logic signed [26:0] n9_reg;
    logic [25:0]        s9_reg;
    side3_t             sd9_reg;

    assign wx_s = signed'({1'b0, sd8_reg.wx});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yk1_reg    <= CW'(sd8_reg.wy) * CW'(k18_reg);
            xk2_reg    <= CW'(wx_s) * CW'(k28_reg);
            xk1_reg    <= CW'(wx_s) * CW'(k18_reg);
            yk2_reg    <= CW'(sd8_reg.wy) * CW'(k28_reg);
            n9_reg     <= n8_reg;
            s9_reg     <= s8_reg;
            sd9_reg.ok <= sd8_reg.ok;
            sd9_reg.bq <= sd8_reg.bq;
        end
    end

    // stage 10: CORDIC operands for both elbow branches
    logic signed [CW-1:0] y1a_reg, x1a_reg, y1b_reg, x1b_reg;
    logic signed [CW-1:0] y2a_reg, y2b_reg, x2_reg;
    logic signed [CW-1:0] s_ext;
    side3_t               sd10_reg;

    assign s_ext = signed'({{(CW-26){1'b0}}, s9_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y1a_reg  <= yk1_reg - xk2_reg;
            x1a_reg  <= xk1_reg + yk2_reg;
            y1b_reg  <= yk1_reg + xk2_reg;
            x1b_reg  <= xk1_reg - yk2_reg;
            y2a_reg  <= s_ext;
            y2b_reg  <= -s_ext;
            x2_reg   <= CW'(n9_reg);
            sd10_reg <= sd9_reg;
        end
    end

    // four angle units
    logic signed [AW-1:0] t1a, t1b, t2a, t2b;
    side3_t               s3d_reg [COR_LAT];

    paik_cordic u_cor_t1a (.clk(clk), .en(adv), .x_in(x1a_reg), .y_in(y1a_reg), .ang(t1a));
    paik_cordic u_cor_t1b (.clk(clk), .en(adv), .x_in(x1b_reg), .y_in(y1b_reg), .ang(t1b));
    paik_cordic u_cor_t2a (.clk(clk), .en(adv), .x_in(x2_reg),  .y_in(y2a_reg), .ang(t2a));
    paik_cordic u_cor_t2b (.clk(clk), .en(adv), .x_in(x2_reg),  .y_in(y2b_reg), .ang(t2b));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3d_reg[0] <= sd10_reg;
            for (int i = 1; i < COR_LAT; i++)
                s3d_reg[i] <= s3d_reg[i-1];
        end
    end

    // round to 1/64 degree with a floor shift, saturate
    function automatic logic [15:0] to_out(input logic signed [27:0] v);
        logic signed [27:0] r;
        logic signed [17:0] q;
        r = v + 28'sd512;
        q = r[27:10];
        if (q > 18'sd32767)
            return 16'h7fff;
        else if (q < -18'sd32768)
            return 16'h8000;
        else
            return q[15:0];
    endfunction

    // output stage: pick the larger shoulder angle, add servo offsets, zero the word when out of reach
    side3_t             sd_c;
    logic signed [27:0] t1, t2;
    logic signed [15:0] base_reg, shoulder_reg, elbow_reg, wrist_reg;
    logic               ok_reg;

    assign sd_c = s3d_reg[COR_LAT-1];
    assign t1   = (t1a >= t1b) ? 28'(t1a) : 28'(t1b);
    assign t2   = (t1a >= t1b) ? 28'(t2a) : 28'(t2b);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_reg <= sd_c.ok;
            if (sd_c.ok)
            begin
                base_reg     <= sd_c.bq;
                shoulder_reg <= to_out(t1);
                elbow_reg    <= to_out(28'(ELBOW_OFF) + t2);
                wrist_reg    <= to_out(28'(WRIST_OFF) + t1 + t2);
            end
            else
            begin
                base_reg     <= '0;
                shoulder_reg <= '0;
                elbow_reg    <= '0;
                wrist_reg    <= '0;
            end
        end
    end

    assign base_angle     = base_reg;
    assign shoulder_angle = shoulder_reg;
    assign elbow_angle    = elbow_reg;
    assign wrist_angle    = wrist_reg;
    assign reach_ok       = ok_reg;

    // unreachable target gives an all-zero word
    a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !reach_ok |-> base_angle == 0 && shoulder_angle == 0
                                      && elbow_angle == 0 && wrist_angle == 0)
        else $error("angles not cleared for unreachable target");

    // a held result freezes the valid chain
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !target_ready |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // a held result stays valid and unchanged
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(shoulder_angle)
                                          && $stable(elbow_angle))
        else $error("held result changed");

endmodule
